/* hdl/abt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_pkg: shared types for the alternating-bit transfer engine
// Event and result transaction structs, event and action codes, register
// indexes.
// ----------------------------------------------------------------------------
package abt_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  RETRY_RESET   = 8'd3;

  // Event kinds
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SEND = 2'd1,
    KIND_PKT  = 2'd2
  } kind_t;

  // Arrived packet types
  typedef enum logic [1:0] {
    PKT_ACK  = 2'd0,
    PKT_DATA = 2'd1,
    PKT_FIN  = 2'd2,
    PKT_UNK  = 2'd3
  } pkt_type_t;

  // Result actions
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_REXMT   = 3'd2,
    ACT_DUP     = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_CONFIRM = 3'd5,
    ACT_FAIL    = 3'd6,
    ACT_ERROR   = 3'd7
  } action_t;

  // Event transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] pkt_type;
    logic       pkt_seq;
  } abt_req_t;

  // Result transaction
  typedef struct packed {
    logic [2:0] action;
    logic       seq_bit;
    logic       ack_pending;
    logic       closed;
  } abt_rsp_t;

endpackage

/* hdl/alternating_bit_transfer_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_bit_transfer_fsm: stop-and-wait alternating-bit engine
// Takes one event a cycle unless stalled (tick, send request, arrived packet)
// and answers each with one result: the action, its sequence bit and link flags.
// ----------------------------------------------------------------------------
// The block accepts one event transaction per clock while req_stall is low,
// and returns exactly one result transaction per event, in order. An event
// is captured in an input register and resolved against the sender/receiver
// state in a single pass into the result register, so it passes the input
// register and then the result register. Sustained rate is one event per
// cycle while the output is not stalled; the state update of that single
// pass sets it. A two-entry input stage keeps the event side running while a
// result waits; req_stall is driven from a register only. Configuration writes
// take effect at once and are meant to be made while the block is idle.
module alternating_bit_transfer_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  abt_pkg::abt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output abt_pkg::abt_rsp_t rsp
);

  // Configuration registers
  logic [15:0] timeout_ticks;
  logic [7:0]  retry_limit;

  // Protocol state
  logic        send_bit, send_bit_next;
  logic        awaiting_ack, awaiting_ack_next;
  logic        expect_bit, expect_bit_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  retry_count, retry_count_next;
  logic        link_closed, link_closed_next;

  // Input stage: main register and skid entry
  abt_pkg::abt_req_t q, skid;
  logic              q_valid, skid_valid;

  logic              accept, advance, consume;
  abt_pkg::abt_rsp_t rsp_next;

  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic        expire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= abt_pkg::TIMEOUT_RESET;
      retry_limit   <= abt_pkg::RETRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abt_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
        abt_pkg::CFG_RETRY:   retry_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;
  assign advance   = !rsp_valid || !rsp_stall;
  assign consume   = q_valid && advance;

  // Refill the input register from skid or port; park in skid when held
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (consume || !q_valid) begin
      if (skid_valid) begin
        q_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        q_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume || !q_valid) begin
      q <= skid_valid ? skid : req;
    end else if (accept) begin
      skid <= req;
    end
  end

  // Timer arithmetic
  assign tick_inc = tick_count + 16'd1;
  assign limit    = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign expire   = tick_inc >= limit;

  // Resolve the event against the current state
  always_comb begin
    send_bit_next     = send_bit;
    awaiting_ack_next = awaiting_ack;
    expect_bit_next   = expect_bit;
    tick_count_next   = tick_count;
    retry_count_next  = retry_count;
    link_closed_next  = link_closed;
    rsp_next.action   = abt_pkg::ACT_ERROR;
    rsp_next.seq_bit  = 1'b0;

    if (link_closed) begin
      // Closed link: ticks are quiet, everything else is an error
      rsp_next.action = (q.kind == abt_pkg::KIND_TICK) ? abt_pkg::ACT_NONE
                                                      : abt_pkg::ACT_ERROR;
    end else begin
      unique case (q.kind)
        abt_pkg::KIND_TICK: begin
          rsp_next.action = abt_pkg::ACT_NONE;
          if (awaiting_ack) begin
            if (!expire) begin
              tick_count_next = tick_inc;
            end else begin
              tick_count_next = 16'd0;
              if (retry_count >= retry_limit) begin
                awaiting_ack_next = 1'b0;
                link_closed_next  = 1'b1;
                rsp_next.action   = abt_pkg::ACT_FAIL;
              end else begin
                retry_count_next = retry_count + 8'd1;
                rsp_next.action  = abt_pkg::ACT_REXMT;
                rsp_next.seq_bit = send_bit;
              end
            end
          end
        end
        abt_pkg::KIND_SEND: begin
          // A send while waiting is refused
          if (!awaiting_ack) begin
            awaiting_ack_next = 1'b1;
            tick_count_next   = 16'd0;
            retry_count_next  = 8'd0;
            rsp_next.action   = abt_pkg::ACT_SEND;
            rsp_next.seq_bit  = send_bit;
          end
        end
        abt_pkg::KIND_PKT: begin
          unique case (q.pkt_type)
            abt_pkg::PKT_ACK: begin
              // Drop stale or unexpected acknowledgements
              rsp_next.action = abt_pkg::ACT_NONE;
              if (awaiting_ack && (q.pkt_seq == send_bit)) begin
                awaiting_ack_next = 1'b0;
                send_bit_next     = ~send_bit;
                tick_count_next   = 16'd0;
                retry_count_next  = 8'd0;
              end
            end
            abt_pkg::PKT_DATA: begin
              rsp_next.seq_bit = q.pkt_seq;
              if (q.pkt_seq == expect_bit) begin
                expect_bit_next = ~expect_bit;
                rsp_next.action = abt_pkg::ACT_DELIVER;
              end else begin
                rsp_next.action = abt_pkg::ACT_DUP;
              end
            end
            abt_pkg::PKT_FIN: begin
              awaiting_ack_next = 1'b0;
              tick_count_next   = 16'd0;
              retry_count_next  = 8'd0;
              link_closed_next  = 1'b1;
              rsp_next.action   = abt_pkg::ACT_CONFIRM;
            end
            default: rsp_next.action = abt_pkg::ACT_ERROR;
          endcase
        end
        default: rsp_next.action = abt_pkg::ACT_ERROR;
      endcase
    end

    rsp_next.ack_pending = awaiting_ack_next;
    rsp_next.closed      = link_closed_next;
  end

  // Advance state on each consumed event
  always_ff @(posedge clk) begin
    if (rst) begin
      send_bit     <= 1'b0;
      awaiting_ack <= 1'b0;
      expect_bit   <= 1'b0;
      tick_count   <= 16'd0;
      retry_count  <= 8'd0;
      link_closed  <= 1'b0;
    end else if (consume) begin
      send_bit     <= send_bit_next;
      awaiting_ack <= awaiting_ack_next;
      expect_bit   <= expect_bit_next;
      tick_count   <= tick_count_next;
      retry_count  <= retry_count_next;
      link_closed  <= link_closed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> q_valid)
    else $error("skid entry held without a main entry");

  a_closed_not_pending: assert property (@(posedge clk) disable iff (rst)
    link_closed |-> !awaiting_ack)
    else $error("closed link still awaiting an acknowledgement");

  a_closed_sticks: assert property (@(posedge clk) disable iff (rst)
    link_closed |=> link_closed)
    else $error("closed link reopened");

  a_send_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (consume && (rsp_next.action == abt_pkg::ACT_SEND)) |=> awaiting_ack)
    else $error("send did not start waiting for an acknowledgement");

endmodule

/* tb/alternating_bit_transfer_fsm_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_bit_transfer_fsm_tb: self-checking bench for the ABT engine
// Feeds tick, send and packet events through the valid/stall port. Transfers
// are well formed, with random tick runs and noise inside them. Every result
// is checked against an in-bench model of the sender and receiver state.
// Timeout and retry settings change between phases while the block is idle.
// The link is closed by retry exhaustion only at the very end, since reset is
// applied once.
// ----------------------------------------------------------------------------
module alternating_bit_transfer_fsm_tb;

  localparam logic [1:0] KIND_BAD    = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         NUM_PHASES  = 5;

  logic      clk = 1'b1;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic      cfg_index = abt_pkg::CFG_TIMEOUT;
  logic [15:0] cfg_data = '0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  abt_pkg::abt_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  abt_pkg::abt_rsp_t rsp;

  // Event transactions waiting to be driven, results still owed by the block
  abt_pkg::abt_req_t event_q[$];
  abt_pkg::abt_rsp_t owed_rsp_q[$];

  // Shadow of the engine state and its registers
  logic        st_send_bit = 1'b0;
  logic        st_waiting = 1'b0;
  logic        st_expect_bit = 1'b0;
  logic [15:0] st_ticks = '0;
  logic [7:0]  st_retries = '0;
  logic        st_closed = 1'b0;
  logic [15:0] reg_timeout = abt_pkg::TIMEOUT_RESET;
  logic [7:0]  reg_retry_lim = abt_pkg::RETRY_RESET;

  // Sender bit as seen by the stimulus generator
  logic        gen_bit = 1'b0;
  int          gen_count = 0;

  logic        req_fire = 1'b0;
  logic        calm = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          err_cnt = 0;
  int          cycles = 0;

  // Per-phase register settings and idling, after the reset-value phase
  int unsigned ph_timeout[NUM_PHASES] = '{0, 4, 1, 65535, 3};
  int unsigned ph_retry[NUM_PHASES]   = '{255, 0, 5, 1, 2};
  int          ph_idle[NUM_PHASES]    = '{88, 0, 35, 0, 35};
  int          ph_stall[NUM_PHASES]   = '{0, 88, 35, 0, 35};

  alternating_bit_transfer_fsm uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Work out the result of one event and advance the shadow state
  function automatic abt_pkg::abt_rsp_t resolve_event(abt_pkg::abt_req_t ev);
    abt_pkg::abt_rsp_t r;
    logic [15:0]       lim;
    r = '0;
    r.action = abt_pkg::ACT_NONE;
    if (st_closed) begin
      r.action = (ev.kind == abt_pkg::KIND_TICK) ? abt_pkg::ACT_NONE
                                                : abt_pkg::ACT_ERROR;
    end else begin
      case (ev.kind)
        abt_pkg::KIND_TICK: begin
          if (st_waiting) begin
            st_ticks = st_ticks + 16'd1;
            lim = (reg_timeout == '0) ? 16'd1 : reg_timeout;
            if (st_ticks >= lim) begin
              st_ticks = '0;
              if (st_retries >= reg_retry_lim) begin
                st_waiting = 1'b0;
                st_closed = 1'b1;
                r.action = abt_pkg::ACT_FAIL;
              end else begin
                st_retries = st_retries + 8'd1;
                r.action = abt_pkg::ACT_REXMT;
                r.seq_bit = st_send_bit;
              end
            end
          end
        end
        abt_pkg::KIND_SEND: begin
          if (st_waiting) begin
            r.action = abt_pkg::ACT_ERROR;
          end else begin
            st_waiting = 1'b1;
            st_ticks = '0;
            st_retries = '0;
            r.action = abt_pkg::ACT_SEND;
            r.seq_bit = st_send_bit;
          end
        end
        abt_pkg::KIND_PKT: begin
          case (ev.pkt_type)
            abt_pkg::PKT_ACK: begin
              if (st_waiting && ev.pkt_seq == st_send_bit) begin
                st_waiting = 1'b0;
                st_send_bit = ~st_send_bit;
                st_ticks = '0;
                st_retries = '0;
              end
            end
            abt_pkg::PKT_DATA: begin
              r.seq_bit = ev.pkt_seq;
              if (ev.pkt_seq == st_expect_bit) begin
                st_expect_bit = ~st_expect_bit;
                r.action = abt_pkg::ACT_DELIVER;
              end else begin
                r.action = abt_pkg::ACT_DUP;
              end
            end
            abt_pkg::PKT_FIN: begin
              st_waiting = 1'b0;
              st_ticks = '0;
              st_retries = '0;
              st_closed = 1'b1;
              r.action = abt_pkg::ACT_CONFIRM;
            end
            default: r.action = abt_pkg::ACT_ERROR;
          endcase
        end
        default: r.action = abt_pkg::ACT_ERROR;
      endcase
    end
    r.ack_pending = st_waiting;
    r.closed = st_closed;
    return r;
  endfunction

  task automatic add_event(input logic [1:0] k, input logic [1:0] pt, input logic s);
    abt_pkg::abt_req_t ev;
    ev.kind = k;
    ev.pkt_type = pt;
    ev.pkt_seq = s;
    event_q.push_back(ev);
    gen_count++;
  endtask

  // Ticks and send requests carry random packet fields, which are ignored
  task automatic add_tick();
    add_event(abt_pkg::KIND_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  task automatic add_send();
    add_event(abt_pkg::KIND_SEND, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // One event that must not complete or break a transfer
  task automatic add_noise(input bit in_transfer);
    case ($urandom_range(5))
      0, 1: add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_DATA, 1'($urandom_range(1)));
      2:    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_UNK, 1'($urandom_range(1)));
      3:    add_event(KIND_BAD, 2'($urandom_range(3)), 1'($urandom_range(1)));
      4: begin
        if (in_transfer) add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, ~gen_bit);
        else add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, 1'($urandom_range(1)));
      end
      default: begin
        if (in_transfer) add_send();
        else add_tick();
      end
    endcase
  endtask

  // Send, a tick run kept short of retry exhaustion, then the matching ACK
  task automatic add_transfer(input int nt);
    add_send();
    while (nt > 0) begin
      if ($urandom_range(3) == 0) begin
        add_noise(1'b1);
      end else begin
        add_tick();
        nt--;
      end
    end
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, gen_bit);
    gen_bit = ~gen_bit;
  endtask

  task automatic add_traffic(input int n);
    int eff;
    int bound;
    int stop;
    eff = (reg_timeout == '0) ? 1 : int'(reg_timeout);
    bound = eff * (int'(reg_retry_lim) + 1) - 1;
    if (bound > 40) bound = 40;
    stop = gen_count + n;
    while (gen_count < stop) begin
      if ($urandom_range(99) < 70) add_transfer($urandom_range(bound));
      else add_noise(1'b0);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == abt_pkg::CFG_TIMEOUT) reg_timeout = val;
    else reg_retry_lim = val[7:0];
  endtask

  // Hold until every event is taken and every result is back
  task automatic wait_idle();
    while (event_q.size() != 0 || req_valid || owed_rsp_q.size() != 0)
      @(posedge clk);
  endtask

  // Drive events and the result stall on the falling edge
  always @(negedge clk) begin
    if (!req_valid || req_fire) begin
      if (event_q.size() != 0 && (calm || $urandom_range(99) >= send_idle_pct)) begin
        req <= event_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_stall <= !calm && ($urandom_range(99) < stall_pct);
    if ($urandom_range(63) == 0) calm <= !calm;
  end

  // Predict on each accepted event, check each accepted result
  always @(posedge clk) begin : mon
    abt_pkg::abt_rsp_t want;
    req_fire <= !rst && req_valid && !req_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: action %0d seq %0b pending %0b closed %0b",
                   rsp.action, rsp.seq_bit, rsp.ack_pending, rsp.closed);
      end else begin
        want = owed_rsp_q.pop_front();
        if (rsp.action !== want.action || rsp.seq_bit !== want.seq_bit ||
            rsp.ack_pending !== want.ack_pending || rsp.closed !== want.closed) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch: action %0d/%0d seq %0b/%0b pending %0b/%0b ",
                      "closed %0b/%0b (expected/actual)"},
                     want.action, rsp.action, want.seq_bit, rsp.seq_bit,
                     want.ack_pending, rsp.ack_pending, want.closed, rsp.closed);
        end
      end
    end
    if (!rst && req_valid && !req_stall) owed_rsp_q.push_back(resolve_event(req));
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[alternating_bit_transfer_fsm] ERROR");
      $finish;
    end
  end

  initial begin : stim
    int p;
    int eff;
    int nt;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle link, receiver, bad codes, two full transfers
    add_tick();
    add_event(KIND_BAD, abt_pkg::PKT_UNK, 1'b1);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_UNK, 1'b0);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, 1'b0);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, 1'b1);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_DATA, 1'b0);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_DATA, 1'b0);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_DATA, 1'b1);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_DATA, 1'b1);
    add_send();
    add_send();
    add_tick();
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, 1'b1);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, 1'b0);
    add_send();
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_DATA, 1'b0);
    add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, 1'b1);
    gen_bit = 1'b0;
    add_traffic(230);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(abt_pkg::CFG_TIMEOUT, ph_timeout[p][15:0]);
      write_reg(abt_pkg::CFG_RETRY, {8'($urandom_range(255)), ph_retry[p][7:0]});
      send_idle_pct = ph_idle[p];
      stall_pct = ph_stall[p];
      // A transfer with a single tick: expires at once on the shortest timeouts
      add_transfer(1);
      add_traffic(p == 3 ? 200 : 230);
      if (p == NUM_PHASES - 1) begin
        // Exhaust the retries, then poke the closed link with every event
        eff = (reg_timeout == '0) ? 1 : int'(reg_timeout);
        add_send();
        for (nt = 0; nt < eff * (int'(reg_retry_lim) + 1); nt++) add_tick();
        add_tick();
        add_send();
        add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_ACK, gen_bit);
        add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_DATA, 1'b0);
        add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_FIN, 1'b1);
        add_event(abt_pkg::KIND_PKT, abt_pkg::PKT_UNK, 1'b0);
        add_event(KIND_BAD, abt_pkg::PKT_DATA, 1'b1);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[alternating_bit_transfer_fsm] OK");
    end else begin
      $display("[alternating_bit_transfer_fsm] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/abt_pkg.sv
hdl/alternating_bit_transfer_fsm.sv
tb/alternating_bit_transfer_fsm_tb.sv
